### rtl/gag_pkg.sv
// Shared types and constants of the im2col gather address generator.
package gag_pkg;

  localparam int unsigned DivSteps   = 24;  // dividend width, one quotient bit per stage
  localparam int unsigned PostStages = 4;   // multiply / add / check / output stages
  localparam int unsigned Latency    = 2 * DivSteps + PostStages;
  localparam int unsigned CfgWidth   = 48;

  localparam logic [12:0] ResetDim          = 13'd1;
  localparam logic [23:0] ResetRowTotal     = 24'd1;
  localparam logic [31:0] ResetWindowShape  = 32'h0101_0100;
  localparam logic [31:0] ResetBlockSplit   = 32'h0001_0001;
  localparam logic [47:0] ResetChannelBytes = 48'd0;

  typedef enum logic [2:0] {
    CfgInHeight     = 3'd0,
    CfgInWidth      = 3'd1,
    CfgOutHeight    = 3'd2,
    CfgOutWidth     = 3'd3,
    CfgRowTotal     = 3'd4,
    CfgWindowShape  = 3'd5,
    CfgBlockSplit   = 3'd6,
    CfgChannelBytes = 3'd7
  } gag_cfg_reg_e;

  // fields carried alongside the second divider pass
  typedef struct packed {
    logic        row_ok;
    logic [11:0] sub;
    logic [9:0]  cb_quot;
    logic [23:0] batch;
  } gag_mid_t;

endpackage

### rtl/gag_div.sv
// Pipelined restoring divider, one quotient bit per stage; zero divisor gives q=0, r=dividend.
module gag_div #(
  parameter int unsigned DW = 24,
  parameter int unsigned VW = 16
) (
  input  logic          clk_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic [DW-1:0] quotient_o,
  output logic [DW-1:0] remainder_o
);

  localparam int unsigned CW = ((DW > VW) ? DW : VW) + 1;

  logic [DW-1:0] rem_q [DW];
  logic [DW-1:0] dvd_q [DW];
  logic [VW-1:0] dsr_q [DW];

  for (genvar g = 0; g < DW; g++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [DW-1:0] dvd_in;
    logic [VW-1:0] dsr_in;
    logic [CW-1:0] trial;
    logic [CW-1:0] dsr_x;
    logic [CW-1:0] diff;
    logic          take;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = dividend_i;
      assign dsr_in = divisor_i;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign dvd_in = dvd_q[g-1];
      assign dsr_in = dsr_q[g-1];
    end

    assign trial = CW'({rem_in, dvd_in[DW-1]});
    assign dsr_x = CW'(dsr_in);
    assign take  = (dsr_in != '0) && (trial >= dsr_x);
    assign diff  = trial - dsr_x;

    always_ff @(posedge clk_i) begin
      rem_q[g] <= take ? diff[DW-1:0] : trial[DW-1:0];
      dvd_q[g] <= {dvd_in[DW-2:0], take};
      dsr_q[g] <= dsr_in;
    end
  end

  assign quotient_o  = dvd_q[DW-1];
  assign remainder_o = rem_q[DW-1];

endmodule

### rtl/im2col_gather_address_gen.sv
// Top level of the im2col gather address generator: config, two divider passes, post stages.
// Pipeline from the accepting edge to the done_o strobe: two 24-step divider
//   passes of one quotient bit per stage, then multiply, add, range check, output stages.
// Throughput: one request per cycle; busy_o is always low, nothing waits on a loop.
// Results are shown for one cycle with done_o; the receiver cannot stall them.
// Reset (rst_ni low, asynchronous): config registers to defaults, all valid bits cleared.
module im2col_gather_address_gen (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  // request
  input  logic        start_i,
  output logic        busy_o,
  input  logic [23:0] row_index_i,
  input  logic [9:0]  column_block_i,
  input  logic [11:0] depth_block_i,
  // result
  output logic        done_o,
  output logic        use_zero_page_o,
  output logic [31:0] stick_index_o,
  output logic [31:0] channel_offset_o,
  output logic [15:0] read_bytes_o,
  output logic [15:0] fill_bytes_o
);

  localparam int unsigned Steps = gag_pkg::DivSteps;
  localparam int unsigned Lat   = gag_pkg::Latency;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [12:0] in_height_q, in_height_d;
  logic [12:0] in_width_q, in_width_d;
  logic [12:0] out_height_q, out_height_d;
  logic [12:0] out_width_q, out_width_d;
  logic [23:0] row_total_q, row_total_d;
  logic [31:0] window_shape_q, window_shape_d;
  logic [31:0] block_split_q, block_split_d;
  logic [47:0] channel_bytes_q, channel_bytes_d;
  logic [25:0] plane_q;   // out_height * out_width, tracks writes on the same edge

  always_comb begin
    in_height_d     = in_height_q;
    in_width_d      = in_width_q;
    out_height_d    = out_height_q;
    out_width_d     = out_width_q;
    row_total_d     = row_total_q;
    window_shape_d  = window_shape_q;
    block_split_d   = block_split_q;
    channel_bytes_d = channel_bytes_q;
    if (cfg_we_i) begin
      unique case (gag_pkg::gag_cfg_reg_e'(cfg_index_i))
        gag_pkg::CfgInHeight:     in_height_d     = cfg_data_i[12:0];
        gag_pkg::CfgInWidth:      in_width_d      = cfg_data_i[12:0];
        gag_pkg::CfgOutHeight:    out_height_d    = cfg_data_i[12:0];
        gag_pkg::CfgOutWidth:     out_width_d     = cfg_data_i[12:0];
        gag_pkg::CfgRowTotal:     row_total_d     = cfg_data_i[23:0];
        gag_pkg::CfgWindowShape:  window_shape_d  = cfg_data_i[31:0];
        gag_pkg::CfgBlockSplit:   block_split_d   = cfg_data_i[31:0];
        gag_pkg::CfgChannelBytes: channel_bytes_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_height_q     <= gag_pkg::ResetDim;
      in_width_q      <= gag_pkg::ResetDim;
      out_height_q    <= gag_pkg::ResetDim;
      out_width_q     <= gag_pkg::ResetDim;
      row_total_q     <= gag_pkg::ResetRowTotal;
      window_shape_q  <= gag_pkg::ResetWindowShape;
      block_split_q   <= gag_pkg::ResetBlockSplit;
      channel_bytes_q <= gag_pkg::ResetChannelBytes;
      plane_q         <= 26'd1;
    end else begin
      in_height_q     <= in_height_d;
      in_width_q      <= in_width_d;
      out_height_q    <= out_height_d;
      out_width_q     <= out_width_d;
      row_total_q     <= row_total_d;
      window_shape_q  <= window_shape_d;
      block_split_q   <= block_split_d;
      channel_bytes_q <= channel_bytes_d;
      plane_q         <= out_height_d * out_width_d;
    end
  end

  // field views
  logic [7:0]  ksize, strd, dil, pad;
  logic [15:0] per_tap, per_cblk, stick, real_bytes, cbstride;
  assign ksize      = window_shape_q[31:24];
  assign strd       = window_shape_q[23:16];
  assign dil        = window_shape_q[15:8];
  assign pad        = window_shape_q[7:0];
  assign per_tap    = block_split_q[31:16];
  assign per_cblk   = block_split_q[15:0];
  assign stick      = channel_bytes_q[47:32];
  assign real_bytes = channel_bytes_q[31:16];
  assign cbstride   = channel_bytes_q[15:0];

  // ---------------------------------------------------------------------------
  // Valid chain: bit k marks the data in register stage k+1. No stalls exist.
  // ---------------------------------------------------------------------------
  logic [Lat-1:0] vld_q;
  logic           accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], accept};
    end
  end

  // ---------------------------------------------------------------------------
  // Pass 1: K-block / per_tap, N-block / per_cblk, row / plane
  // ---------------------------------------------------------------------------
  logic [23:0] tap_q1, tap_r1, cb_q1, cb_r1, row_q1, row_r1;

  gag_div #(.DW(Steps), .VW(16)) u_div_tap (
    .clk_i, .dividend_i(24'(depth_block_i)), .divisor_i(per_tap),
    .quotient_o(tap_q1), .remainder_o(tap_r1)
  );
  gag_div #(.DW(Steps), .VW(16)) u_div_cb (
    .clk_i, .dividend_i(24'(column_block_i)), .divisor_i(per_cblk),
    .quotient_o(cb_q1), .remainder_o(cb_r1)
  );
  gag_div #(.DW(Steps), .VW(26)) u_div_row (
    .clk_i, .dividend_i(row_index_i), .divisor_i(plane_q),
    .quotient_o(row_q1), .remainder_o(row_r1)
  );

  // row range check travels beside pass 1
  logic row_ok_q [Steps];
  always_ff @(posedge clk_i) begin
    row_ok_q[0] <= row_index_i < row_total_q;
    for (int i = 1; i < Steps; i++) row_ok_q[i] <= row_ok_q[i-1];
  end

  // ---------------------------------------------------------------------------
  // Pass 2: tap / ksize -> (kh, kw), plane remainder / out_width -> (ho, wo)
  // ---------------------------------------------------------------------------
  logic [23:0] kh_full, kw_full, ho, wo;

  gag_div #(.DW(Steps), .VW(8)) u_div_kern (
    .clk_i, .dividend_i(24'(tap_q1[11:0])), .divisor_i(ksize),
    .quotient_o(kh_full), .remainder_o(kw_full)
  );
  gag_div #(.DW(Steps), .VW(13)) u_div_pos (
    .clk_i, .dividend_i(row_r1), .divisor_i(out_width_q),
    .quotient_o(ho), .remainder_o(wo)
  );

  gag_pkg::gag_mid_t mid_d;
  gag_pkg::gag_mid_t mid_q [Steps];
  assign mid_d = '{row_ok: row_ok_q[Steps-1], sub: tap_r1[11:0],
                   cb_quot: cb_q1[9:0], batch: row_q1};
  always_ff @(posedge clk_i) begin
    mid_q[0] <= mid_d;
    for (int i = 1; i < Steps; i++) mid_q[i] <= mid_q[i-1];
  end

  // ---------------------------------------------------------------------------
  // P1: products
  // ---------------------------------------------------------------------------
  gag_pkg::gag_mid_t mid;
  logic [31:0] hm_q, wm_q, np_q;
  logic [19:0] dkh_q, dkw_q;
  logic [25:0] c1_q;
  logic [27:0] c2_q;
  logic        ok1_q;
  logic [36:0] np_full;
  assign mid     = mid_q[Steps-1];
  assign np_full = mid.batch * in_height_q;

  always_ff @(posedge clk_i) begin
    hm_q  <= ho * strd;
    wm_q  <= wo * strd;
    dkh_q <= dil * kh_full[11:0];
    dkw_q <= dil * kw_full[11:0];   // kw is below 4096: it never exceeds the tap
    c1_q  <= mid.cb_quot * cbstride;
    c2_q  <= mid.sub * stick;
    np_q  <= np_full[31:0];
    ok1_q <= mid.row_ok;
  end

  // ---------------------------------------------------------------------------
  // P2: input position (bit 33 is the sign), channel offset
  // ---------------------------------------------------------------------------
  logic [33:0] hi_q, wi_q;
  logic [31:0] choff2_q, np2_q;
  logic        ok2_q;
  always_ff @(posedge clk_i) begin
    hi_q     <= 34'(hm_q) + 34'(dkh_q) - 34'(pad);
    wi_q     <= 34'(wm_q) + 34'(dkw_q) - 34'(pad);
    choff2_q <= 32'(c1_q) + 32'(c2_q);
    np2_q    <= np_q;
    ok2_q    <= ok1_q;
  end

  // ---------------------------------------------------------------------------
  // P3: range check, stick base, read/fill split
  // ---------------------------------------------------------------------------
  logic        in_ok;
  logic [15:0] remaining, rd;
  logic [31:0] base3_q, wi3_q, choff3_q;
  logic [15:0] rd3_q, fill3_q;
  logic        ok3_q;

  assign in_ok = !hi_q[33] && !wi_q[33] &&
                 (hi_q[32:0] < 33'(in_height_q)) && (wi_q[32:0] < 33'(in_width_q));
  assign remaining = (32'(real_bytes) > choff2_q) ? (real_bytes - choff2_q[15:0]) : 16'd0;
  assign rd        = (remaining < stick) ? remaining : stick;

  always_ff @(posedge clk_i) begin
    base3_q  <= np2_q + hi_q[31:0];
    wi3_q    <= wi_q[31:0];
    choff3_q <= choff2_q;
    rd3_q    <= rd;
    fill3_q  <= stick - rd;
    ok3_q    <= ok2_q && in_ok;
  end

  // ---------------------------------------------------------------------------
  // P4: stick index and output register
  // ---------------------------------------------------------------------------
  logic [44:0] page_prod;
  logic [31:0] page;
  logic        final_ok;
  assign page_prod = base3_q * in_width_q;
  assign page      = page_prod[31:0] + wi3_q;
  assign final_ok  = ok3_q && (rd3_q != 16'd0);

  always_ff @(posedge clk_i) begin
    use_zero_page_o  <= !final_ok;
    stick_index_o    <= final_ok ? page : 32'd0;
    channel_offset_o <= final_ok ? choff3_q : 32'd0;
    read_bytes_o     <= final_ok ? rd3_q : stick;
    fill_bytes_o     <= final_ok ? fill3_q : 16'd0;
  end

  assign done_o = vld_q[Lat-1];

`ifndef SYNTH
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Lat))
    else $error("result strobe without a request transfer at fixed latency");

  a_zero_page_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && use_zero_page_o) |-> (stick_index_o == 32'd0 && fill_bytes_o == 16'd0 &&
                                     channel_offset_o == 32'd0))
    else $error("zero page result carries a source address");

  a_read_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !use_zero_page_o) |-> (read_bytes_o != 16'd0))
    else $error("real stick read with zero length");
`endif

endmodule
